// ===== rtl/srev_pkg.sv =====
// Shared types and constants for the stream group reverser.
package srev_pkg;

   localparam int MAX_GROUP_DEF = 64;  // default depth of the cell chain
   localparam int VALUE_W       = 32;  // element width
   localparam int GSIZE_W       = 7;   // group size register width

   // Shift command broadcast to every cell of the chain
   typedef logic [1:0] shift_mode_type;
   localparam shift_mode_type SHIFT_HOLD = 2'd0;
   localparam shift_mode_type SHIFT_UP   = 2'd1;  // toward the tail, cell 0 loads input
   localparam shift_mode_type SHIFT_DOWN = 2'd2;  // toward the head, head is popped

   // Result request from the controller to the output register
   typedef struct packed {
      logic valid;
      logic last;
      logic done;
      logic from_tail;  // 1: take the tail cell, 0: take the head cell
   } emit_type;

endpackage

// ===== rtl/srev_cell.sv =====
// One storage cell of the reversing chain.
module srev_cell (
   input  logic                            clock,
   input  srev_pkg::shift_mode_type        mode,
   input  logic [srev_pkg::VALUE_W-1:0]    from_lower,
   input  logic [srev_pkg::VALUE_W-1:0]    from_upper,
   output logic [srev_pkg::VALUE_W-1:0]    value_ff
);
   import srev_pkg::*;

   logic [VALUE_W-1:0] value_in;

   always_comb begin
      case (mode)
         SHIFT_UP:   value_in = from_lower;
         SHIFT_DOWN: value_in = from_upper;
         default:    value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== rtl/srev_ctrl.sv =====
// Sequencer: group size register, fill count, drain and alignment counters.
module srev_ctrl #(
   parameter int MAX_GROUP = srev_pkg::MAX_GROUP_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tlast,
   output logic                            req_tready,
   input  logic                            csr_valid,
   input  logic [srev_pkg::GSIZE_W-1:0]    csr_wdata,
   output logic                            csr_ready,
   input  logic                            out_free,
   output srev_pkg::shift_mode_type        mode,
   output srev_pkg::emit_type              emit
);
   import srev_pkg::*;

   localparam int CW = $clog2(MAX_GROUP + 1);

   localparam logic [1:0] ST_ACCEPT = 2'd0;
   localparam logic [1:0] ST_LIFO   = 2'd1;
   localparam logic [1:0] ST_ALIGN  = 2'd2;
   localparam logic [1:0] ST_FIFO   = 2'd3;

   logic [1:0]         state_ff,  state_in;
   logic [CW-1:0]      fill_ff,   fill_in;
   logic [CW-1:0]      remain_ff, remain_in;
   logic [CW-1:0]      align_ff,  align_in;
   logic               end_ff,    end_in;
   logic [GSIZE_W-1:0] gsize_ff,  gsize_in;

   logic [CW-1:0]      eff_size;
   logic [CW-1:0]      next_fill;
   logic [CW-1:0]      gap;
   logic               accept;
   logic               is_last;

   // zero acts as one, anything above the chain depth saturates
   always_comb begin
      if (gsize_ff == '0) begin
         eff_size = CW'(1);
      end else if (gsize_ff > GSIZE_W'(MAX_GROUP)) begin
         eff_size = CW'(MAX_GROUP);
      end else begin
         eff_size = CW'(gsize_ff);
      end
   end

   assign csr_ready  = 1'b1;
   assign gsize_in   = (csr_valid && csr_ready) ? csr_wdata : gsize_ff;
   assign req_tready = (state_ff == ST_ACCEPT);
   assign accept     = req_tvalid && req_tready;
   assign next_fill  = fill_ff + CW'(1);
   assign gap        = CW'(MAX_GROUP) - next_fill;
   assign is_last    = (remain_ff == CW'(1));

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      remain_in = remain_ff;
      align_in  = align_ff;
      end_in    = end_ff;
      mode      = SHIFT_HOLD;
      emit      = '0;
      case (state_ff)
         ST_ACCEPT: begin
            if (accept) begin
               mode = SHIFT_UP;
               if (next_fill >= eff_size) begin
                  remain_in = next_fill;
                  end_in    = req_tlast;
                  fill_in   = '0;
                  state_in  = ST_LIFO;
               end else if (req_tlast) begin
                  // partial group: move it to the tail, then drain oldest first
                  remain_in = next_fill;
                  end_in    = 1'b1;
                  fill_in   = '0;
                  align_in  = gap;
                  state_in  = (gap == '0) ? ST_FIFO : ST_ALIGN;
               end else begin
                  fill_in = next_fill;
               end
            end
         end
         ST_LIFO: begin
            if (out_free) begin
               mode           = SHIFT_DOWN;
               emit.valid     = 1'b1;
               emit.last      = is_last;
               emit.done      = is_last && end_ff;
               emit.from_tail = 1'b0;
               remain_in      = remain_ff - CW'(1);
               if (is_last) begin
                  state_in = ST_ACCEPT;
               end
            end
         end
         ST_ALIGN: begin
            mode     = SHIFT_UP;
            align_in = align_ff - CW'(1);
            if (align_ff == CW'(1)) begin
               state_in = ST_FIFO;
            end
         end
         ST_FIFO: begin
            if (out_free) begin
               mode           = SHIFT_UP;
               emit.valid     = 1'b1;
               emit.last      = is_last;
               emit.done      = is_last;
               emit.from_tail = 1'b1;
               remain_in      = remain_ff - CW'(1);
               if (is_last) begin
                  state_in = ST_ACCEPT;
               end
            end
         end
         default: begin
            state_in = ST_ACCEPT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_ACCEPT;
         fill_ff   <= '0;
         remain_ff <= '0;
         align_ff  <= '0;
         end_ff    <= 1'b0;
         gsize_ff  <= GSIZE_W'(1);
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         remain_ff <= remain_in;
         align_ff  <= align_in;
         end_ff    <= end_in;
         gsize_ff  <= gsize_in;
      end
   end

endmodule

// ===== rtl/stream_group_reverser.sv =====
// Top level: cell chain, sequencer and result register of the group reverser.
//
//  channel  direction  transaction payload
//  -------  ---------  ---------------------------------------------------------
//  req_*    in         tdata = item_value[31:0], tlast = list_end
//  rsp_*    out        tdata = out_value[31:0], tlast = run_last, tuser = list_done
//  csr_*    in         wdata = group_size[6:0]
//
//  Items enter one per cycle while a group fills, each into cell 0 as the chain
//  shifts toward the tail. A completed group of n drains newest first from
//  cell 0; a partial group of n at list end shifts up by MAX_GROUP-n cells to
//  reach the tail cell, then drains oldest first from the tail cell.
//  Input waits during a drain; a stalled result only holds the drain.
//  Synchronous reset empties the group and sets group_size to 1, not the cells.
module stream_group_reverser #(
   parameter int MAX_GROUP = srev_pkg::MAX_GROUP_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // item_value[31:0]
   input  logic signed [srev_pkg::VALUE_W-1:0] req_tdata,
   input  logic                              req_tlast,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // out_value[31:0]
   output logic signed [srev_pkg::VALUE_W-1:0] rsp_tdata,
   output logic                              rsp_tlast,
   // list_done[0]
   output logic                              rsp_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [srev_pkg::GSIZE_W-1:0]      csr_wdata
);
   import srev_pkg::*;

   shift_mode_type     mode;
   emit_type           emit;
   logic               out_free;
   logic [VALUE_W-1:0] cell_q [MAX_GROUP];

   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [VALUE_W-1:0] rsp_data_ff,   rsp_data_in;
   logic               rsp_last_ff,   rsp_last_in;
   logic               rsp_done_ff,   rsp_done_in;

   // result register can take a new result when empty or being drained
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   srev_ctrl #(
      .MAX_GROUP (MAX_GROUP)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .csr_valid  (csr_valid),
      .csr_wdata  (csr_wdata),
      .csr_ready  (csr_ready),
      .out_free   (out_free),
      .mode       (mode),
      .emit       (emit)
   );

   // cell 0 is the head (input side), cell MAX_GROUP-1 the tail
   for (genvar i = 0; i < MAX_GROUP; i++) begin : g_cell
      logic [VALUE_W-1:0] lower_d;
      logic [VALUE_W-1:0] upper_d;
      if (i == 0) begin : g_head
         assign lower_d = req_tdata;
      end else begin : g_mid_lo
         assign lower_d = cell_q[i-1];
      end
      if (i == MAX_GROUP - 1) begin : g_tail
         assign upper_d = cell_q[i];
      end else begin : g_mid_hi
         assign upper_d = cell_q[i+1];
      end
      srev_cell u_cell (
         .clock      (clock),
         .mode       (mode),
         .from_lower (lower_d),
         .from_upper (upper_d),
         .value_ff   (cell_q[i])
      );
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_done_in   = rsp_done_ff;
      if (out_free) begin
         rsp_tvalid_in = emit.valid;
         rsp_data_in   = emit.from_tail ? cell_q[MAX_GROUP-1] : cell_q[0];
         rsp_last_in   = emit.last;
         rsp_done_in   = emit.done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_done_ff;

`ifndef SYNTHESIS
   // a result is only requested when the result register can take it
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> out_free)
      else $error("result requested while result register is full");

   // every drained result moves the chain
   a_emit_shift: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> (mode != SHIFT_HOLD))
      else $error("result drained without shifting the chain");

   // no new item is taken while a drain is pending
   a_no_accept_drain: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> !req_tready)
      else $error("input accepted during drain");

   // the end-of-list result always closes its run
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("list_done without run_last");
`endif

endmodule

// ===== verif/srev_check_pkg.sv =====
// Expected-result predictor and result checker for the group reverser testbench.
package srev_check_pkg;
   import srev_pkg::*;

   localparam int GROUP_CAP = MAX_GROUP_DEF;

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic                      run_last;
      logic                      list_done;
   } reorder_result_type;

   class reorder_checker;
      logic [GSIZE_W-1:0]        group_size;
      logic signed [VALUE_W-1:0] held [GROUP_CAP];
      int unsigned               fill;
      reorder_result_type        due_results[$];
      int                        mismatches;
      int                        results_seen;
      int                        lists_closed;

      function new();
         mismatches   = 0;
         results_seen = 0;
         lists_closed = 0;
         clear();
      endfunction

      function void clear();
         group_size = 1;
         fill       = 0;
         due_results.delete();
      endfunction

      function void write_size(logic [GSIZE_W-1:0] size);
         group_size = size;
      endfunction

      // zero acts as 1, oversize saturates to the buffer depth
      function int unsigned group_span();
         if (group_size == 0) return 1;
         if (group_size > GROUP_CAP) return GROUP_CAP;
         return group_size;
      endfunction

      function void note_item(logic signed [VALUE_W-1:0] value, logic ends_list);
         int unsigned        span;
         reorder_result_type r;
         span = group_span();
         if (fill >= GROUP_CAP) fill = GROUP_CAP - 1;
         held[fill] = value;
         fill++;
         if (fill >= span) begin
            // complete group: newest first
            for (int unsigned i = 0; i < fill; i++) begin
               r.value     = held[fill - 1 - i];
               r.run_last  = (i + 1 == fill);
               r.list_done = (i + 1 == fill) && ends_list;
               due_results.push_back(r);
            end
            fill = 0;
         end else if (ends_list) begin
            // partial group at list end: original order
            for (int unsigned i = 0; i < fill; i++) begin
               r.value     = held[i];
               r.run_last  = (i + 1 == fill);
               r.list_done = (i + 1 == fill);
               due_results.push_back(r);
            end
            fill = 0;
         end
      endfunction

      function void flag(string what);
         mismatches++;
         if (mismatches <= 10) $display("MISMATCH: %s", what);
      endfunction

      function void check_result(logic signed [VALUE_W-1:0] value, logic run_last,
                                 logic list_done);
         reorder_result_type want;
         results_seen++;
         if (list_done === 1'b1) lists_closed++;
         if (due_results.size() == 0) begin
            flag($sformatf("unexpected result value=%0d last=%b done=%b",
                           value, run_last, list_done));
            return;
         end
         want = due_results.pop_front();
         if (want.value !== value || want.run_last !== run_last
             || want.list_done !== list_done)
            flag($sformatf("expected value=%0d last=%b done=%b, got value=%0d last=%b done=%b",
                           want.value, want.run_last, want.list_done,
                           value, run_last, list_done));
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      function void close_out();
         reorder_result_type want;
         while (due_results.size() != 0) begin
            want = due_results.pop_front();
            flag($sformatf("missing result value=%0d last=%b done=%b",
                           want.value, want.run_last, want.list_done));
         end
      endfunction
   endclass

endpackage

// ===== verif/tb.sv =====
// Self-checking testbench for the stream group reverser.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import srev_pkg::*;
   import srev_check_pkg::*;

   // Longest quiet stretch: the receiver hold-off, a full partial-group drain
   // and the settle pause each fit well inside this.
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD      = 300;
   // A partial group walks up to the tail of the chain before it drains.
   localparam int DRAIN_CYCLES   = 2 * GROUP_CAP + 8;
   localparam int DIRECTED_ITEMS = 43;
   localparam int RANDOM_ITEMS   = 40;
   localparam int FINAL_ITEMS    = 13;
   localparam int ITEM_TARGET    = DIRECTED_ITEMS + RANDOM_ITEMS + GROUP_CAP + FINAL_ITEMS;

   logic clock;
   logic reset = 1'b1;

   logic signed [VALUE_W-1:0] req_tdata  = '0;
   logic                      req_tlast  = 1'b0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic signed [VALUE_W-1:0] rsp_tdata;
   logic                      rsp_tlast;
   logic                      rsp_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [GSIZE_W-1:0]        csr_wdata  = '0;

   reorder_checker chk = new();

   // Stimulus knobs shared between the driver and the receiver
   bit idle_on        = 1'b1;
   bit long_hold_req  = 1'b0;
   bit long_hold_done = 1'b0;

   int items_sent    = 0;
   int sizes_written = 0;
   int quiet_cycles  = 0;

   stream_group_reverser u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),   // item_value[31:0]
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),   // out_value[31:0]
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),   // list_done[0]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Transaction monitor: every handshake is seen here and nowhere else.
   // Results are checked before the same-edge input is noted; the block
   // cannot answer an item on the edge that takes it.
   always @(posedge clock) begin
      if (reset) begin
         chk.clear();
      end else begin
         if (rsp_tvalid && rsp_tready) chk.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
         if (req_tvalid && req_tready) chk.note_item(req_tdata, req_tlast);
         if (csr_valid && csr_ready) chk.write_size(csr_wdata);
      end
   end

   // Watchdog: counts edges with no transaction on any channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Result receiver: random stall bursts, one long hold-off on request,
   // always ready once idling is switched off.
   initial begin : sink
      @(posedge clock iff !reset);
      forever begin
         if (long_hold_req && !long_hold_done) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_done = 1'b1;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // One input transaction, with an optional idle burst ahead of it.
   // Called at a rising edge; returns on the edge that accepts the item.
   task automatic send_value(input logic signed [VALUE_W-1:0] value, input logic ends_list);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tdata  <= value;
      req_tlast  <= ends_list;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // Extremes show up often so sign and carry bits get exercised
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return '0;
         3:       return -1;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_list(input int len, input bit closed);
      for (int i = 0; i < len; i++) send_value(pick_value(), closed && (i == len - 1));
   endtask

   // Stop offering input, let every expected result arrive, then give the
   // chain time to finish any drain that owes nothing more.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (chk.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Only called after settle(), so the block is idle
   task automatic set_group_size(input logic [GSIZE_W-1:0] size);
      csr_wdata <= size;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      sizes_written++;
   endtask

   // Mostly small groups; zero and mid sizes now and then
   function automatic logic [GSIZE_W-1:0] pick_size();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 7'd1;
         2:       return 7'($urandom_range(9, 16));
         default: return 7'($urandom_range(2, 8));
      endcase
   endfunction

   initial begin : stimulus
      logic [GSIZE_W-1:0] size;
      int                 span;
      int                 phase_no;
      int                 len;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      // reset size of 1: straight pass-through, extremes of the value
      send_value(32'sh8000_0000, 1'b0);
      send_value(32'sh7FFF_FFFF, 1'b1);
      settle();
      // size zero behaves as 1
      set_group_size(7'd0);
      send_value(-1, 1'b0);
      send_value('0, 1'b1);
      settle();
      // group of 3 reversed, then a partial group of 1 at list end
      set_group_size(7'd3);
      send_list(4, 1'b1);
      // group completes exactly on the list end: done on the last of the run
      send_list(3, 1'b1);
      settle();
      // oversize saturates; a short list exits as a partial group in order
      set_group_size(7'd127);
      send_list(2, 1'b1);
      settle();
      // size lowered mid-group: the next item flushes all five held, reversed
      set_group_size(7'd6);
      send_list(4, 1'b0);
      settle();
      set_group_size(7'd2);
      send_value(pick_value(), 1'b0);
      send_value(pick_value(), 1'b1);
      settle();
      // receiver holds off for a long stretch while items keep coming
      set_group_size(7'd4);
      long_hold_req = 1'b1;
      send_list(24, 1'b1);

      // ---- random part: phases of lists at varying sizes ----
      phase_no = 0;
      while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         // sender pauses until every expected result has come
         settle();
         size = pick_size();
         span = (size == 0) ? 1 : size;
         set_group_size(size);
         idle_on = (phase_no == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
         for (int l = $urandom_range(1, 4);
              l > 0 && items_sent < DIRECTED_ITEMS + RANDOM_ITEMS; l--) begin
            len = $urandom_range(1, 2 * span + 3);
            if (len > DIRECTED_ITEMS + RANDOM_ITEMS - items_sent)
               len = DIRECTED_ITEMS + RANDOM_ITEMS - items_sent;
            // an open list now and then leaves a partial group for the next size
            send_list(len, (l != 1) || ($urandom_range(0, 5) != 0));
         end
         phase_no++;
      end

      // one deep group at the full buffer depth
      settle();
      case ($urandom_range(0, 2))
         0:       set_group_size(7'd64);
         1:       set_group_size(7'd65);
         default: set_group_size(7'd127);
      endcase
      idle_on = 1'b1;
      send_list($urandom_range(GROUP_CAP, GROUP_CAP + 6), 1'b1);

      // closing stretch with no idling on either side
      settle();
      set_group_size(7'd5);
      idle_on = 1'b0;
      while (items_sent < ITEM_TARGET) begin
         len = $urandom_range(1, 13);
         if (len > ITEM_TARGET - items_sent) len = ITEM_TARGET - items_sent;
         send_list(len, 1'b1);
      end

      settle();
      chk.close_out();

      $display("Covered %0d input and %0d result transactions over %0d lists, %0d size writes",
               items_sent, chk.results_seen, chk.lists_closed, sizes_written);
      $display("Long receiver hold-off %0s, mismatches %0d",
               long_hold_done ? "done" : "not reached", chk.mismatches);
      if (chk.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
